// ===== src/cbld_pkg.sv =====
// Shared types, constants and register codes for the clipped bit-plane line drawer.
package cbld_pkg;

    localparam int COORD_BITS_DEF     = 12;
    localparam int MAX_HEIGHT_DEF     = 1024;
    localparam int MAX_BPL_DEF        = 255;

    localparam int WIN_BITS      = 11;
    localparam int PEN_BITS      = 7;
    localparam int FMT_BITS      = 2;
    localparam int BPL_BITS      = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 11;
    localparam int OFFSET_BITS   = 18;
    localparam int CMP_BITS      = 18;
    localparam int COL_BITS      = 10;
    localparam int PEN_XOR_BIT   = 6;

    localparam logic [7:0] MASK_2BPP = 8'hC0;
    localparam logic [7:0] MASK_1BPP = 8'h80;
    localparam logic [7:0] BITS_HI   = 8'hAA;
    localparam logic [7:0] BITS_LO   = 8'h55;

    localparam logic [FMT_BITS-1:0] FMT_MONO  = 2'd0;
    localparam logic [FMT_BITS-1:0] FMT_1BPP  = 2'd1;
    localparam logic [FMT_BITS-1:0] FMT_2BPP  = 2'd2;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [WIN_BITS-1:0] RST_WINDOW_LEFT    = 11'd0;
    localparam logic [WIN_BITS-1:0] RST_WINDOW_RIGHT   = 11'd639;
    localparam logic [WIN_BITS-1:0] RST_WINDOW_BOTTOM  = 11'd0;
    localparam logic [WIN_BITS-1:0] RST_WINDOW_TOP     = 11'd239;
    localparam logic [PEN_BITS-1:0] RST_PEN            = 7'd7;
    localparam logic [WIN_BITS-1:0] RST_SCREEN_HEIGHT  = 11'd240;
    localparam logic [BPL_BITS-1:0] RST_BYTES_PER_LINE = 8'd80;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WINDOW_LEFT,
        CFG_WINDOW_RIGHT,
        CFG_WINDOW_BOTTOM,
        CFG_WINDOW_TOP,
        CFG_PEN,
        CFG_PIXEL_FORMAT,
        CFG_SCREEN_HEIGHT,
        CFG_BYTES_PER_LINE
    } t_cfg_idx;

    typedef struct packed {
        logic [WIN_BITS-1:0] window_left;
        logic [WIN_BITS-1:0] window_right;
        logic [WIN_BITS-1:0] window_bottom;
        logic [WIN_BITS-1:0] window_top;
        logic [PEN_BITS-1:0] pen;
        logic [FMT_BITS-1:0] pixel_format;
        logic [WIN_BITS-1:0] screen_height;
        logic [BPL_BITS-1:0] bytes_per_line;
    } t_cfg;

    typedef struct packed {
        logic active;
        logic done;
    } t_pix_ctl;

endpackage

// ===== src/cbld_if.sv =====
// Handshake interfaces for the command, result and register write channels.
interface cbld_in_if import cbld_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source(output valid, op, start_x, start_y, end_x, end_y, input ready);
    modport sink(input valid, op, start_x, start_y, end_x, end_y, output ready);
endinterface

interface cbld_out_if import cbld_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   write_enable;
    logic [OFFSET_BITS-1:0] byte_offset;
    logic [7:0]             bit_mask;
    logic [7:0]             plane0_bits;
    logic [7:0]             plane1_bits;
    logic [7:0]             plane2_bits;
    logic                   xor_write;
    logic                   three_planes;
    logic                   line_done;

    modport source(output valid, write_enable, byte_offset, bit_mask, plane0_bits,
                   plane1_bits, plane2_bits, xor_write, three_planes, line_done,
                   input ready);
    modport sink(input valid, write_enable, byte_offset, bit_mask, plane0_bits,
                 plane1_bits, plane2_bits, xor_write, three_planes, line_done,
                 output ready);
endinterface

interface cbld_cfg_if import cbld_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== src/cbld_front.sv =====
// Command front end: accepts items, tags steps, and queues them for the engine.
module cbld_front import cbld_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    cbld_in_if.sink                      i_in,
    output logic                         o_q_valid,
    input  logic                         i_q_ready,
    output logic                         o_q_step,
    output logic signed [COORD_BITS-1:0] o_q_sx,
    output logic signed [COORD_BITS-1:0] o_q_sy,
    output logic signed [COORD_BITS-1:0] o_q_ex,
    output logic signed [COORD_BITS-1:0] o_q_ey
);

    logic                         r_wr_ptr;
    logic                         r_rd_ptr;
    logic [1:0]                   r_count;
    logic                         r_step [2];
    logic signed [COORD_BITS-1:0] r_sx   [2];
    logic signed [COORD_BITS-1:0] r_sy   [2];
    logic signed [COORD_BITS-1:0] r_ex   [2];
    logic signed [COORD_BITS-1:0] r_ey   [2];
    logic                         push;
    logic                         pop;

    assign i_in.ready = (r_count != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign pop        = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_step[r_wr_ptr] <= (i_in.op == OP_STEP);
            r_sx[r_wr_ptr]   <= i_in.start_x;
            r_sy[r_wr_ptr]   <= i_in.start_y;
            r_ex[r_wr_ptr]   <= i_in.end_x;
            r_ey[r_wr_ptr]   <= i_in.end_y;
        end
    end

    assign o_q_valid = (r_count != 2'd0);
    assign o_q_step  = r_step[r_rd_ptr];
    assign o_q_sx    = r_sx[r_rd_ptr];
    assign o_q_sy    = r_sy[r_rd_ptr];
    assign o_q_ex    = r_ex[r_rd_ptr];
    assign o_q_ey    = r_ey[r_rd_ptr];

endmodule

// ===== src/cbld_engine.sv =====
// Bresenham engine: loads endpoints on start and walks one pixel per step.
module cbld_engine import cbld_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    output logic                         o_q_ready,
    input  logic                         i_q_step,
    input  logic signed [COORD_BITS-1:0] i_q_sx,
    input  logic signed [COORD_BITS-1:0] i_q_sy,
    input  logic signed [COORD_BITS-1:0] i_q_ex,
    input  logic signed [COORD_BITS-1:0] i_q_ey,
    output logic                         o_pix_valid,
    input  logic                         i_pix_ready,
    output t_pix_ctl                     o_pix_ctl,
    output logic signed [COORD_BITS-1:0] o_pix_x,
    output logic signed [COORD_BITS-1:0] o_pix_y
);

    localparam int DW  = COORD_BITS + 1;
    localparam int EW  = COORD_BITS + 2;
    localparam int E2W = COORD_BITS + 3;

    logic signed [COORD_BITS-1:0] r_cur_x;
    logic signed [COORD_BITS-1:0] r_cur_y;
    logic signed [COORD_BITS-1:0] r_tgt_x;
    logic signed [COORD_BITS-1:0] r_tgt_y;
    logic signed [DW-1:0]         r_dx;
    logic signed [DW-1:0]         r_dy_neg;
    logic                         r_sxn;
    logic                         r_syn;
    logic signed [EW-1:0]         r_err;
    logic                         r_active;

    logic                         r_pix_valid;
    t_pix_ctl                     r_pix_ctl;
    logic signed [COORD_BITS-1:0] r_pix_x;
    logic signed [COORD_BITS-1:0] r_pix_y;

    logic                 out_free;
    logic                 take;
    logic                 do_start;
    logic                 do_step;
    logic signed [DW-1:0] sx_w;
    logic signed [DW-1:0] sy_w;
    logic signed [DW-1:0] ex_w;
    logic signed [DW-1:0] ey_w;
    logic signed [DW-1:0] n_dx;
    logic signed [DW-1:0] n_dy_neg;
    logic signed [EW-1:0] n_err_start;
    logic signed [E2W-1:0] e2;
    logic                 go_x;
    logic                 go_y;
    logic                 at_end;
    logic signed [EW-1:0] n_err_step;

    assign out_free  = !r_pix_valid || i_pix_ready;
    assign o_q_ready = !i_q_step || out_free;
    assign take      = i_q_valid && o_q_ready;
    assign do_start  = take && !i_q_step;
    assign do_step   = take && i_q_step;

    always_comb begin
        sx_w        = DW'(i_q_sx);
        sy_w        = DW'(i_q_sy);
        ex_w        = DW'(i_q_ex);
        ey_w        = DW'(i_q_ey);
        n_dx        = (ex_w >= sx_w) ? (ex_w - sx_w) : (sx_w - ex_w);
        n_dy_neg    = (ey_w >= sy_w) ? (sy_w - ey_w) : (ey_w - sy_w);
        n_err_start = EW'(n_dx) + EW'(n_dy_neg);
    end

    always_comb begin
        e2         = $signed({r_err, 1'b0});
        go_x       = (e2 >= E2W'(r_dy_neg));
        go_y       = (e2 <= E2W'(r_dx));
        at_end     = (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y);
        n_err_step = r_err + (go_x ? EW'(r_dy_neg) : EW'(0)) + (go_y ? EW'(r_dx) : EW'(0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_tgt_x  <= '0;
            r_tgt_y  <= '0;
            r_dx     <= '0;
            r_dy_neg <= '0;
            r_sxn    <= 1'b0;
            r_syn    <= 1'b0;
            r_err    <= '0;
            r_active <= 1'b0;
        end else if (do_start) begin
            r_cur_x  <= i_q_sx;
            r_cur_y  <= i_q_sy;
            r_tgt_x  <= i_q_ex;
            r_tgt_y  <= i_q_ey;
            r_dx     <= n_dx;
            r_dy_neg <= n_dy_neg;
            r_sxn    <= !(i_q_sx < i_q_ex);
            r_syn    <= !(i_q_sy < i_q_ey);
            r_err    <= n_err_start;
            r_active <= 1'b1;
        end else if (do_step && r_active) begin
            if (at_end) begin
                r_active <= 1'b0;
            end else begin
                r_err <= n_err_step;
                if (go_x) begin
                    r_cur_x <= r_sxn ? (r_cur_x - 1'b1) : (r_cur_x + 1'b1);
                end
                if (go_y) begin
                    r_cur_y <= r_syn ? (r_cur_y - 1'b1) : (r_cur_y + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= 1'b0;
        end else if (out_free) begin
            r_pix_valid <= do_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_step) begin
            r_pix_ctl.active <= r_active;
            r_pix_ctl.done   <= !r_active || at_end;
            r_pix_x          <= r_cur_x;
            r_pix_y          <= r_cur_y;
        end
    end

    assign o_pix_valid = r_pix_valid;
    assign o_pix_ctl   = r_pix_ctl;
    assign o_pix_x     = r_pix_x;
    assign o_pix_y     = r_pix_y;

endmodule

// ===== src/cbld_pix.sv =====
// Pixel back end: clips, builds mask and plane bits, then forms the byte offset.
module cbld_pix import cbld_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_BYTES_PER_LINE = MAX_BPL_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cfg                         i_cfg,
    input  logic                         i_pix_valid,
    output logic                         o_pix_ready,
    input  t_pix_ctl                     i_pix_ctl,
    input  logic signed [COORD_BITS-1:0] i_pix_x,
    input  logic signed [COORD_BITS-1:0] i_pix_y,
    cbld_out_if.source                   o_out
);

    logic signed [CMP_BITS-1:0] xs;
    logic signed [CMP_BITS-1:0] ys;
    logic [WIN_BITS-1:0]        h;
    logic [BPL_BITS-1:0]        bpl;
    logic [WIN_BITS-1:0]        ux;
    logic [WIN_BITS-1:0]        uy;
    logic                       two_bpp;
    logic                       in_win;
    logic [COL_BITS-1:0]        col;
    logic                       we;
    logic [7:0]                 mask;
    logic [7:0]                 planes [3];

    logic                 a_free;
    logic                 b_free;

    logic                 r_a_valid;
    logic                 r_a_we;
    logic                 r_a_done;
    logic [COL_BITS-1:0]  r_a_col;
    logic [WIN_BITS-1:0]  r_a_row;
    logic [7:0]           r_a_mask;
    logic [7:0]           r_a_p0;
    logic [7:0]           r_a_p1;
    logic [7:0]           r_a_p2;
    logic                 r_a_xor;
    logic                 r_a_three;

    logic [OFFSET_BITS:0] n_offset;

    logic                   r_out_valid;
    logic                   r_out_we;
    logic [OFFSET_BITS-1:0] r_out_offset;
    logic [7:0]             r_out_mask;
    logic [7:0]             r_out_p0;
    logic [7:0]             r_out_p1;
    logic [7:0]             r_out_p2;
    logic                   r_out_xor;
    logic                   r_out_three;
    logic                   r_out_done;

    always_comb begin
        xs  = CMP_BITS'(i_pix_x);
        ys  = CMP_BITS'(i_pix_y);
        h   = (32'(i_cfg.screen_height) > MAX_HEIGHT) ? WIN_BITS'(MAX_HEIGHT)
                                                      : i_cfg.screen_height;
        bpl = (32'(i_cfg.bytes_per_line) > MAX_BYTES_PER_LINE)
                  ? BPL_BITS'(MAX_BYTES_PER_LINE) : i_cfg.bytes_per_line;
        ux  = xs[WIN_BITS-1:0];
        uy  = ys[WIN_BITS-1:0];
        two_bpp = (i_cfg.pixel_format == FMT_2BPP);
        in_win  = (xs >= $signed(CMP_BITS'(i_cfg.window_left)))
               && (xs <= $signed(CMP_BITS'(i_cfg.window_right)))
               && (ys >= $signed(CMP_BITS'(i_cfg.window_bottom)))
               && (ys <= $signed(CMP_BITS'(i_cfg.window_top)));
        col  = two_bpp ? COL_BITS'(ux >> 2) : COL_BITS'(ux >> 3);
        we   = i_pix_ctl.active && in_win && (uy < h)
            && (col < COL_BITS'(bpl));
        mask = two_bpp ? (MASK_2BPP >> {ux[1:0], 1'b0}) : (MASK_1BPP >> ux[2:0]);
        for (int k = 0; k < 3; k++) begin
            if (two_bpp) begin
                planes[k] = (i_cfg.pen[k] ? (mask & BITS_HI) : 8'h00)
                          | (i_cfg.pen[k+3] ? (mask & BITS_LO) : 8'h00);
            end else begin
                planes[k] = i_cfg.pen[k] ? mask : 8'h00;
            end
        end
        if (i_cfg.pixel_format == FMT_MONO) begin
            planes[1] = 8'h00;
            planes[2] = 8'h00;
        end
    end

    assign b_free      = !r_out_valid || o_out.ready;
    assign a_free      = !r_a_valid || b_free;
    assign o_pix_ready = a_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid <= i_pix_valid;
            end
            if (b_free) begin
                r_out_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_free && i_pix_valid) begin
            r_a_we    <= we;
            r_a_done  <= i_pix_ctl.done;
            r_a_col   <= we ? col : '0;
            r_a_row   <= we ? (h - WIN_BITS'(1) - uy) : '0;
            r_a_mask  <= we ? mask : 8'h00;
            r_a_p0    <= we ? planes[0] : 8'h00;
            r_a_p1    <= we ? planes[1] : 8'h00;
            r_a_p2    <= we ? planes[2] : 8'h00;
            r_a_xor   <= we && i_cfg.pen[PEN_XOR_BIT];
            r_a_three <= we && (i_cfg.pixel_format != FMT_MONO);
        end
    end

    assign n_offset = (OFFSET_BITS + 1)'(r_a_row) * (OFFSET_BITS + 1)'(bpl)
                    + (OFFSET_BITS + 1)'(r_a_col);

    always_ff @(posedge i_clk) begin
        if (b_free && r_a_valid) begin
            r_out_we     <= r_a_we;
            r_out_offset <= n_offset[OFFSET_BITS-1:0];
            r_out_mask   <= r_a_mask;
            r_out_p0     <= r_a_p0;
            r_out_p1     <= r_a_p1;
            r_out_p2     <= r_a_p2;
            r_out_xor    <= r_a_xor;
            r_out_three  <= r_a_three;
            r_out_done   <= r_a_done;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.write_enable = r_out_we;
    assign o_out.byte_offset  = r_out_offset;
    assign o_out.bit_mask     = r_out_mask;
    assign o_out.plane0_bits  = r_out_p0;
    assign o_out.plane1_bits  = r_out_p1;
    assign o_out.plane2_bits  = r_out_p2;
    assign o_out.xor_write    = r_out_xor;
    assign o_out.three_planes = r_out_three;
    assign o_out.line_done    = r_out_done;

endmodule

// ===== src/clipped_bitplane_line_drawer_top.sv =====
// Top level of the clipped bit-plane line drawer: register file and pipeline wiring.
//
// A start command loads two endpoints and gives no result; each step command gives one result
// for the current pixel and, until the end pixel, advances one Bresenham step, so a line of N
// pixels takes one start and N steps, and the step result carrying line_done marks its end.
// Results pass the command queue, the engine's pixel register and the clip and offset stages;
// the rate is one command per clock while the output is not stalled. A two-entry command
// queue separates intake from the engine, and two registered stages (clip and mask, then the
// row-times-pitch multiply) follow the engine. Register writes are always accepted and must
// only be issued while no line work is in flight.
module clipped_bitplane_line_drawer_top import cbld_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int MAX_BYTES_PER_LINE = MAX_BPL_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cbld_in_if.sink     i_in,
    cbld_out_if.source  o_out,
    cbld_cfg_if.sink    i_cfg
);

    t_cfg r_cfg;

    logic                         q_valid;
    logic                         q_ready;
    logic                         q_step;
    logic signed [COORD_BITS-1:0] q_sx;
    logic signed [COORD_BITS-1:0] q_sy;
    logic signed [COORD_BITS-1:0] q_ex;
    logic signed [COORD_BITS-1:0] q_ey;

    logic                         pix_valid;
    logic                         pix_ready;
    t_pix_ctl                     pix_ctl;
    logic signed [COORD_BITS-1:0] pix_x;
    logic signed [COORD_BITS-1:0] pix_y;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_left    <= RST_WINDOW_LEFT;
            r_cfg.window_right   <= RST_WINDOW_RIGHT;
            r_cfg.window_bottom  <= RST_WINDOW_BOTTOM;
            r_cfg.window_top     <= RST_WINDOW_TOP;
            r_cfg.pen            <= RST_PEN;
            r_cfg.pixel_format   <= FMT_1BPP;
            r_cfg.screen_height  <= RST_SCREEN_HEIGHT;
            r_cfg.bytes_per_line <= RST_BYTES_PER_LINE;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_WINDOW_LEFT:    r_cfg.window_left    <= i_cfg.data;
                CFG_WINDOW_RIGHT:   r_cfg.window_right   <= i_cfg.data;
                CFG_WINDOW_BOTTOM:  r_cfg.window_bottom  <= i_cfg.data;
                CFG_WINDOW_TOP:     r_cfg.window_top     <= i_cfg.data;
                CFG_PEN:            r_cfg.pen            <= i_cfg.data[PEN_BITS-1:0];
                CFG_PIXEL_FORMAT:   r_cfg.pixel_format   <= i_cfg.data[FMT_BITS-1:0];
                CFG_SCREEN_HEIGHT:  r_cfg.screen_height  <= i_cfg.data;
                CFG_BYTES_PER_LINE: r_cfg.bytes_per_line <= i_cfg.data[BPL_BITS-1:0];
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    cbld_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_step  (q_step),
        .o_q_sx    (q_sx),
        .o_q_sy    (q_sy),
        .o_q_ex    (q_ex),
        .o_q_ey    (q_ey)
    );

    cbld_engine #(
        .COORD_BITS(COORD_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_step    (q_step),
        .i_q_sx      (q_sx),
        .i_q_sy      (q_sy),
        .i_q_ex      (q_ex),
        .i_q_ey      (q_ey),
        .o_pix_valid (pix_valid),
        .i_pix_ready (pix_ready),
        .o_pix_ctl   (pix_ctl),
        .o_pix_x     (pix_x),
        .o_pix_y     (pix_y)
    );

    cbld_pix #(
        .COORD_BITS         (COORD_BITS),
        .MAX_HEIGHT         (MAX_HEIGHT),
        .MAX_BYTES_PER_LINE (MAX_BYTES_PER_LINE)
    ) u_pix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pix_valid (pix_valid),
        .o_pix_ready (pix_ready),
        .i_pix_ctl   (pix_ctl),
        .i_pix_x     (pix_x),
        .i_pix_y     (pix_y),
        .o_out       (o_out)
    );

endmodule

// ===== bench/cbld_pixel_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the line drawer: follows register writes and commands, predicts and checks pixels.
module cbld_pixel_checker import cbld_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    cbld_in_if   i_cmd,
    cbld_out_if  i_pix,
    cbld_cfg_if  i_reg,
    output int   o_mismatches,
    output int   o_owed
);

    localparam int CW = COORD_BITS_DEF;
    localparam int RW = CW + 1;
    localparam int EW = CW + 2;

    typedef struct packed {
        logic                   write_enable;
        logic [OFFSET_BITS-1:0] byte_offset;
        logic [7:0]             bit_mask;
        logic [7:0]             plane0_bits;
        logic [7:0]             plane1_bits;
        logic [7:0]             plane2_bits;
        logic                   xor_write;
        logic                   three_planes;
        logic                   line_done;
    } t_pixel_write;

    logic signed [CW-1:0] cur_x, cur_y, tgt_x, tgt_y;
    logic signed [RW-1:0] run_x, rise_neg;
    logic signed [EW-1:0] err;
    logic                 x_back, y_back, line_live;

    logic [WIN_BITS-1:0]  win_left, win_right, win_bottom, win_top, scr_height;
    logic [PEN_BITS-1:0]  pen_reg;
    logic [FMT_BITS-1:0]  fmt_reg;
    logic [BPL_BITS-1:0]  bpl_reg;

    t_pixel_write pixel_queue [$];

    initial o_mismatches = 0;

    task automatic flag_mismatch(string msg);
        $display("[%0t] pixel check: %s", $time, msg);
        o_mismatches++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] expected);
        if (got !== expected) begin
            flag_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, expected));
        end
    endtask

    function automatic t_pixel_write plot_pixel();
        t_pixel_write pw;
        int           x, y, h, bpl, col;
        logic         two_bpp;
        logic [7:0]   mask;
        logic [7:0]   planes [3];
        pw      = '0;
        x       = int'(cur_x);
        y       = int'(cur_y);
        h       = (int'(scr_height) > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(scr_height);
        bpl     = (int'(bpl_reg) > MAX_BPL_DEF) ? MAX_BPL_DEF : int'(bpl_reg);
        two_bpp = (fmt_reg == FMT_2BPP);
        if (x < int'(win_left) || x > int'(win_right)) return pw;
        if (y < int'(win_bottom) || y > int'(win_top)) return pw;
        if (y >= h) return pw;
        col = two_bpp ? (x >> 2) : (x >> 3);
        if (col >= bpl) return pw;
        mask = two_bpp ? (MASK_2BPP >> (2 * (x & 3))) : (MASK_1BPP >> (x & 7));
        for (int k = 0; k < 3; k++) begin
            planes[k] = '0;
            if (two_bpp) begin
                if (pen_reg[k]) planes[k] = planes[k] | (mask & BITS_HI);
                if (pen_reg[k + 3]) planes[k] = planes[k] | (mask & BITS_LO);
            end else if (pen_reg[k]) begin
                planes[k] = mask;
            end
        end
        if (fmt_reg == FMT_MONO) begin
            planes[1] = '0;
            planes[2] = '0;
        end
        pw.write_enable = 1'b1;
        pw.byte_offset  = OFFSET_BITS'(col + (h - 1 - y) * bpl);
        pw.bit_mask     = mask;
        pw.plane0_bits  = planes[0];
        pw.plane1_bits  = planes[1];
        pw.plane2_bits  = planes[2];
        pw.xor_write    = pen_reg[PEN_XOR_BIT];
        pw.three_planes = (fmt_reg != FMT_MONO);
        return pw;
    endfunction

    task automatic trace_command(input logic op, input logic signed [CW-1:0] sx, sy, ex, ey);
        t_pixel_write pw;
        int           dx, dy, e2;
        if (op == OP_START) begin
            cur_x     = sx;
            cur_y     = sy;
            tgt_x     = ex;
            tgt_y     = ey;
            dx        = int'(ex) - int'(sx);
            dy        = int'(ey) - int'(sy);
            run_x     = RW'((dx < 0) ? -dx : dx);
            rise_neg  = RW'((dy < 0) ? dy : -dy);
            x_back    = !(sx < ex);
            y_back    = !(sy < ey);
            err       = run_x + rise_neg;
            line_live = 1'b1;
        end else begin
            if (!line_live) begin
                pw           = '0;
                pw.line_done = 1'b1;
            end else begin
                pw = plot_pixel();
                if (cur_x == tgt_x && cur_y == tgt_y) begin
                    line_live    = 1'b0;
                    pw.line_done = 1'b1;
                end else begin
                    e2 = 2 * int'(err);
                    if (e2 >= int'(rise_neg)) begin
                        err   = err + rise_neg;
                        cur_x = x_back ? cur_x - 1'b1 : cur_x + 1'b1;
                    end
                    if (e2 <= int'(run_x)) begin
                        err   = err + run_x;
                        cur_y = y_back ? cur_y - 1'b1 : cur_y + 1'b1;
                    end
                end
            end
            pixel_queue.push_back(pw);
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_write want;
        if (!i_rst_n) begin
            pixel_queue.delete();
            cur_x      = '0;
            cur_y      = '0;
            tgt_x      = '0;
            tgt_y      = '0;
            run_x      = '0;
            rise_neg   = '0;
            err        = '0;
            x_back     = 1'b0;
            y_back     = 1'b0;
            line_live  = 1'b0;
            win_left   = RST_WINDOW_LEFT;
            win_right  = RST_WINDOW_RIGHT;
            win_bottom = RST_WINDOW_BOTTOM;
            win_top    = RST_WINDOW_TOP;
            pen_reg    = RST_PEN;
            fmt_reg    = FMT_1BPP;
            scr_height = RST_SCREEN_HEIGHT;
            bpl_reg    = RST_BYTES_PER_LINE;
            o_owed    <= 0;
        end else begin
            if (i_pix.valid && i_pix.ready) begin
                if (pixel_queue.size() == 0) begin
                    flag_mismatch("pixel transfer with nothing expected");
                end else begin
                    want = pixel_queue.pop_front();
                    check_field("write_enable", i_pix.write_enable, want.write_enable);
                    check_field("byte_offset", i_pix.byte_offset, want.byte_offset);
                    check_field("bit_mask", i_pix.bit_mask, want.bit_mask);
                    check_field("plane0_bits", i_pix.plane0_bits, want.plane0_bits);
                    check_field("plane1_bits", i_pix.plane1_bits, want.plane1_bits);
                    check_field("plane2_bits", i_pix.plane2_bits, want.plane2_bits);
                    check_field("xor_write", i_pix.xor_write, want.xor_write);
                    check_field("three_planes", i_pix.three_planes, want.three_planes);
                    check_field("line_done", i_pix.line_done, want.line_done);
                end
            end
            if (i_reg.valid && i_reg.ready) begin
                case (t_cfg_idx'(i_reg.index))
                    CFG_WINDOW_LEFT:    win_left   = i_reg.data[WIN_BITS-1:0];
                    CFG_WINDOW_RIGHT:   win_right  = i_reg.data[WIN_BITS-1:0];
                    CFG_WINDOW_BOTTOM:  win_bottom = i_reg.data[WIN_BITS-1:0];
                    CFG_WINDOW_TOP:     win_top    = i_reg.data[WIN_BITS-1:0];
                    CFG_PEN:            pen_reg    = i_reg.data[PEN_BITS-1:0];
                    CFG_PIXEL_FORMAT:   fmt_reg    = i_reg.data[FMT_BITS-1:0];
                    CFG_SCREEN_HEIGHT:  scr_height = i_reg.data[WIN_BITS-1:0];
                    CFG_BYTES_PER_LINE: bpl_reg    = i_reg.data[BPL_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.valid && i_cmd.ready) begin
                trace_command(i_cmd.op, i_cmd.start_x, i_cmd.start_y, i_cmd.end_x, i_cmd.end_y);
            end
            o_owed <= pixel_queue.size();
        end
    end

endmodule

// ===== bench/clipped_bitplane_line_drawer_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the line drawer: clock, reset, command and register stimulus, verdict.
module clipped_bitplane_line_drawer_top_tb;
    import cbld_pkg::*;

    localparam int CW            = COORD_BITS_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 35;
    localparam int NUM_PHASES    = 7;
    localparam logic [FMT_BITS-1:0] FMT_SPARE = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   mismatches;
    int   pixels_owed;
    int   cycle_count = 0;
    bit   steady = 1'b0;
    bit   hold_off_req = 1'b0;
    logic [CFG_DATA_BITS-1:0] setup [8];

    cbld_in_if  in_bus();
    cbld_out_if out_bus();
    cbld_cfg_if cfg_bus();

    clipped_bitplane_line_drawer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    cbld_pixel_checker u_pixel_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (in_bus),
        .i_pix        (out_bus),
        .i_reg        (cfg_bus),
        .o_mismatches (mismatches),
        .o_owed       (pixels_owed)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("clipped_bitplane_line_drawer_top: mismatch");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int clamp_coord(int v);
        if (v < -2048) return -2048;
        if (v > 2047) return 2047;
        return v;
    endfunction

    function automatic int junk_coord();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    function automatic int magnitude(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int pick_coord(int lo, int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70 && lo <= hi) return clamp_coord(int'($urandom_range(0, hi - lo + 12)) + lo - 6);
        if (r < 80) return int'($urandom_range(0, 15)) - 8;
        return junk_coord();
    endfunction

    task automatic send_cmd(logic op, int sx, int sy, int ex, int ey);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.op      <= op;
        in_bus.start_x <= CW'(sx);
        in_bus.start_y <= CW'(sy);
        in_bus.end_x   <= CW'(ex);
        in_bus.end_y   <= CW'(ey);
        do @(posedge i_clk); while (!in_bus.ready);
    endtask

    task automatic send_line(int sx, int sy, int ex, int ey, int steps);
        send_cmd(OP_START, sx, sy, ex, ey);
        repeat (steps) send_cmd(OP_STEP, junk_coord(), junk_coord(), junk_coord(), junk_coord());
    endtask

    task automatic settle();
        in_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pixels_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_setup();
        for (int k = CFG_WINDOW_LEFT; k <= CFG_BYTES_PER_LINE; k++) begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= t_cfg_idx'(k);
            cfg_bus.data  <= setup[k];
            do @(posedge i_clk); while (!cfg_bus.ready);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic random_lines(int budget);
        int used, sx, sy, ex, ey, len, steps, kind, spread;
        used = 0;
        while (used < budget) begin
            kind   = $urandom_range(0, 99);
            steady = ($urandom_range(0, 3) == 0);
            sx = pick_coord(setup[CFG_WINDOW_LEFT], setup[CFG_WINDOW_RIGHT]);
            sy = pick_coord(setup[CFG_WINDOW_BOTTOM], setup[CFG_WINDOW_TOP]);
            if (kind < 85) begin
                spread = (kind < 70) ? 10 : 60;
                ex = clamp_coord(sx + int'($urandom_range(0, 2 * spread)) - spread);
                ey = clamp_coord(sy + int'($urandom_range(0, 2 * spread)) - spread);
            end else begin
                ex = junk_coord();
                ey = junk_coord();
            end
            len = magnitude(ex - sx);
            if (magnitude(ey - sy) > len) len = magnitude(ey - sy);
            len = len + 1;
            kind = $urandom_range(0, 99);
            if (len > 70) steps = $urandom_range(0, 30);
            else if (kind < 75) steps = len;
            else if (kind < 88) steps = len + $urandom_range(1, 3);
            else steps = $urandom_range(0, len - 1);
            send_line(sx, sy, ex, ey, steps);
            used += steps + 1;
        end
        steady = 1'b0;
    endtask

    initial begin : result_sink
        int beat, stall_pct, stall_left;
        beat       = 0;
        stall_pct  = 0;
        stall_left = 0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            beat++;
            if (beat % 64 == 0) begin
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (stall_left > 0) begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
                if ($urandom_range(0, 99) < stall_pct) stall_left = pick_gap();
            end
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        in_bus.valid   <= 1'b0;
        in_bus.op      <= OP_STEP;
        in_bus.start_x <= '0;
        in_bus.start_y <= '0;
        in_bus.end_x   <= '0;
        in_bus.end_y   <= '0;
        cfg_bus.valid  <= 1'b0;
        cfg_bus.index  <= CFG_WINDOW_LEFT;
        cfg_bus.data   <= '0;
        setup = '{RST_WINDOW_LEFT, RST_WINDOW_RIGHT, RST_WINDOW_BOTTOM, RST_WINDOW_TOP,
                  RST_PEN, FMT_1BPP, RST_SCREEN_HEIGHT, RST_BYTES_PER_LINE};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle step, single-pixel plot, extremes, abandon, window edges, leftward run
        send_cmd(OP_STEP, 0, 0, 0, 0);
        send_line(5, 5, 5, 5, 1);
        send_line(-2048, -2048, 2047, 2047, 2);
        send_line(0, 0, 3, 1, 4);
        send_line(639, 239, 641, 237, 3);
        send_line(2, 3, -1, 3, 4);
        send_cmd(OP_STEP, -1, -1, -1, -1);
        send_line(2047, -1, -2048, 2047, 0);
        send_line(100, 2047, 100, -2048, 1);
        random_lines(50);

        for (int phase = 1; phase <= NUM_PHASES; phase++) begin
            settle();
            case (phase)
                1: setup = '{0, 2047, 0, 2047, 127, FMT_MONO, 2047, 255};
                2: setup = '{10, 100, 5, 60, CFG_DATA_BITS'($urandom_range(0, 127)),
                             FMT_2BPP, 64, 16};
                3: setup = '{0, 0, 0, 0, 0, FMT_SPARE, 1, 1};
                4: setup = '{700, 600, 50, 40, CFG_DATA_BITS'($urandom_range(0, 127)),
                             FMT_1BPP, 0, 0};
                5: begin
                    for (int k = 0; k < 8; k++) setup[k] = CFG_DATA_BITS'($urandom_range(0, 2047));
                end
                default: begin
                    setup[CFG_WINDOW_LEFT]    = CFG_DATA_BITS'($urandom_range(0, 200));
                    setup[CFG_WINDOW_RIGHT]   = CFG_DATA_BITS'(int'(setup[CFG_WINDOW_LEFT])
                                                + int'($urandom_range(0, 500)));
                    setup[CFG_WINDOW_BOTTOM]  = CFG_DATA_BITS'($urandom_range(0, 100));
                    setup[CFG_WINDOW_TOP]     = CFG_DATA_BITS'(int'(setup[CFG_WINDOW_BOTTOM])
                                                + int'($urandom_range(0, 300)));
                    setup[CFG_PEN]            = CFG_DATA_BITS'($urandom_range(0, 127));
                    setup[CFG_PIXEL_FORMAT]   = CFG_DATA_BITS'($urandom_range(0, 3));
                    setup[CFG_SCREEN_HEIGHT]  = CFG_DATA_BITS'($urandom_range(1, 1024));
                    setup[CFG_BYTES_PER_LINE] = CFG_DATA_BITS'($urandom_range(1, 255));
                end
            endcase
            program_setup();
            if (phase == 2) begin
                // stall the result side while a long line streams in back to back
                hold_off_req = 1'b1;
                steady       = 1'b1;
                send_line(8, 4, 95, 50, 88);
                steady       = 1'b0;
            end
            random_lines(PHASE_ITEMS);
        end
        settle();

        if (mismatches == 0 && pixels_owed == 0) begin
            $display("clipped_bitplane_line_drawer_top: match");
        end else begin
            $display("clipped_bitplane_line_drawer_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/cbld_pkg.sv
src/cbld_if.sv
src/cbld_front.sv
src/cbld_engine.sv
src/cbld_pix.sv
src/clipped_bitplane_line_drawer_top.sv
bench/cbld_pixel_checker.sv
bench/clipped_bitplane_line_drawer_top_tb.sv
